// ===== rtl/mpec_pkg.sv =====
// ----------------------------------------------------------------------------
// mpec_pkg
// Shared types, constants and helpers for the Mandelbrot escape counter.
// ----------------------------------------------------------------------------
package mpec_pkg;

    localparam int COORD_W     = 12;
    localparam int FIX_W       = 32;
    localparam int FRAC_BITS   = 24;
    localparam int SHIFT_W     = 16;
    localparam int LIMIT_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int PROD_W      = 2 * FIX_W;
    localparam int WIDE_W      = PROD_W + 2;
    localparam int OFFSET_W    = 18;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;

    localparam int FRAME_WIDTH_DEF  = 4096;
    localparam int FRAME_HEIGHT_DEF = 4096;

    // |z|^2 bound: 4.0 in Q16.48
    localparam logic [PROD_W:0] ESCAPE_BOUND = (PROD_W + 1)'(4) << (2 * FRAC_BITS);

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_REAL_MIN   = 3'd0;
    localparam logic [2:0] REG_IMAG_MIN   = 3'd1;
    localparam logic [2:0] REG_REAL_STEP  = 3'd2;
    localparam logic [2:0] REG_IMAG_STEP  = 3'd3;
    localparam logic [2:0] REG_COL_SHIFT  = 3'd4;
    localparam logic [2:0] REG_ROW_SHIFT  = 3'd5;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd6;

    localparam logic signed [FIX_W-1:0]   RESET_AXIS_MIN = -32'sd33554432;
    localparam logic signed [FIX_W-1:0]   RESET_STEP     = 32'sd65536;
    localparam logic signed [SHIFT_W-1:0] RESET_SHIFT    = '0;
    localparam logic [LIMIT_W-1:0]        RESET_LIMIT    = 16'd64;

    typedef struct packed {
        logic signed [FIX_W-1:0]   real_axis_min;
        logic signed [FIX_W-1:0]   imag_axis_min;
        logic signed [FIX_W-1:0]   real_step;
        logic signed [FIX_W-1:0]   imag_step;
        logic signed [SHIFT_W-1:0] column_shift;
        logic signed [SHIFT_W-1:0] row_shift;
        logic [LIMIT_W-1:0]        iteration_limit;
    } cfg_t;

    typedef struct packed {
        logic load_pixel;
        logic map_mul;
        logic map_add;
        logic iter_mul;
        logic iter_upd;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic escape;
        logic at_limit;
    } dp_stat_t;

    // saturate a wide signed value to the 32 bit signed range
    function automatic logic signed [FIX_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic all_ones;
        logic all_zeros;
        all_ones  = &v[WIDE_W-1:FIX_W-1];
        all_zeros = ~|v[WIDE_W-1:FIX_W-1];
        if (all_ones || all_zeros)
        begin
            sat32 = v[FIX_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            sat32 = {1'b1, {(FIX_W-1){1'b0}}};
        end
        else
        begin
            sat32 = {1'b0, {(FIX_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== rtl/mpec_if.sv =====
// ----------------------------------------------------------------------------
// mpec_if
// Valid/ready channels for pixel items and result items.
// ----------------------------------------------------------------------------
interface mpec_pixel_if;
    logic                             valid;
    logic                             ready;
    logic [mpec_pkg::COORD_W-1:0]     pixel_col;
    logic [mpec_pkg::COORD_W-1:0]     pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mpec_result_if;
    logic                             valid;
    logic                             ready;
    logic [mpec_pkg::COUNT_W-1:0]     iteration_count;
    logic                             escaped;

    modport source (output valid, output iteration_count, output escaped, input ready);
    modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface

// ===== rtl/mpec_cfg.sv =====
// ----------------------------------------------------------------------------
// mpec_cfg
// APB register file holding the view window and iteration limit.
// ----------------------------------------------------------------------------
module mpec_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mpec_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mpec_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mpec_pkg::APB_DATA_W-1:0]     prdata,
    output mpec_pkg::cfg_t                      cfg
);

    mpec_pkg::cfg_t cfg_reg;
    mpec_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[mpec_pkg::APB_ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                mpec_pkg::REG_REAL_MIN:   cfg_next.real_axis_min   = pwdata;
                mpec_pkg::REG_IMAG_MIN:   cfg_next.imag_axis_min   = pwdata;
                mpec_pkg::REG_REAL_STEP:  cfg_next.real_step       = pwdata;
                mpec_pkg::REG_IMAG_STEP:  cfg_next.imag_step       = pwdata;
                mpec_pkg::REG_COL_SHIFT:  cfg_next.column_shift    = pwdata[15:0];
                mpec_pkg::REG_ROW_SHIFT:  cfg_next.row_shift       = pwdata[15:0];
                mpec_pkg::REG_ITER_LIMIT: cfg_next.iteration_limit = pwdata[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_axis_min   <= mpec_pkg::RESET_AXIS_MIN;
            cfg_reg.imag_axis_min   <= mpec_pkg::RESET_AXIS_MIN;
            cfg_reg.real_step       <= mpec_pkg::RESET_STEP;
            cfg_reg.imag_step       <= mpec_pkg::RESET_STEP;
            cfg_reg.column_shift    <= mpec_pkg::RESET_SHIFT;
            cfg_reg.row_shift       <= mpec_pkg::RESET_SHIFT;
            cfg_reg.iteration_limit <= mpec_pkg::RESET_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            mpec_pkg::REG_REAL_MIN:   prdata = cfg_reg.real_axis_min;
            mpec_pkg::REG_IMAG_MIN:   prdata = cfg_reg.imag_axis_min;
            mpec_pkg::REG_REAL_STEP:  prdata = cfg_reg.real_step;
            mpec_pkg::REG_IMAG_STEP:  prdata = cfg_reg.imag_step;
            mpec_pkg::REG_COL_SHIFT:  prdata = 32'(cfg_reg.column_shift);
            mpec_pkg::REG_ROW_SHIFT:  prdata = 32'(cfg_reg.row_shift);
            mpec_pkg::REG_ITER_LIMIT: prdata = {16'd0, cfg_reg.iteration_limit};
            default:                  prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/mpec_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpec_ctrl
// Sequencer: point mapping, then multiply/update pairs until escape or limit.
// ----------------------------------------------------------------------------
module mpec_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  mpec_pkg::dp_stat_t      stat,
    output mpec_pkg::ctrl_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MAP_MUL  = 3'd1;
    localparam logic [2:0] S_MAP_ADD  = 3'd2;
    localparam logic [2:0] S_ITER_MUL = 3'd3;
    localparam logic [2:0] S_ITER_UPD = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = S_MAP_MUL;
                end
            end
            S_MAP_MUL:
            begin
                cmd.map_mul = 1'b1;
                state_next  = S_MAP_ADD;
            end
            S_MAP_ADD:
            begin
                cmd.map_add = 1'b1;
                state_next  = S_ITER_MUL;
            end
            S_ITER_MUL:
            begin
                cmd.iter_mul = 1'b1;
                state_next   = S_ITER_UPD;
            end
            S_ITER_UPD:
            begin
                if (stat.escape || stat.at_limit)
                begin
                    // hold here until the result register is free
                    if (out_free)
                    begin
                        cmd.finish     = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.iter_upd = 1'b1;
                    state_next   = S_ITER_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/mpec_dp.sv =====
// ----------------------------------------------------------------------------
// mpec_dp
// Datapath: three 32x32 multipliers (two shared between mapping and iteration), z/c registers, escape test.
// ----------------------------------------------------------------------------
module mpec_dp
#(
    parameter int FRAME_WIDTH  = mpec_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = mpec_pkg::FRAME_HEIGHT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mpec_pkg::cfg_t                      cfg,
    input  mpec_pkg::ctrl_cmd_t                 cmd,
    output mpec_pkg::dp_stat_t                  stat,
    input  logic [mpec_pkg::COORD_W-1:0]        pixel_col,
    input  logic [mpec_pkg::COORD_W-1:0]        pixel_row,
    output logic [mpec_pkg::COUNT_W-1:0]        iteration_count,
    output logic                                escaped
);

    localparam int CW = mpec_pkg::COORD_W;
    localparam int FW = mpec_pkg::FIX_W;
    localparam int PW = mpec_pkg::PROD_W;
    localparam int WW = mpec_pkg::WIDE_W;
    localparam int OW = mpec_pkg::OFFSET_W;
    localparam int NW = mpec_pkg::COUNT_W;
    localparam int FB = mpec_pkg::FRAC_BITS;

    localparam logic [CW:0] COL_LAST = (CW + 1)'(FRAME_WIDTH - 1);
    localparam logic [CW:0] ROW_LAST = (CW + 1)'(FRAME_HEIGHT - 1);

    logic [CW:0]              col_reg;
    logic [CW:0]              row_reg;
    logic signed [FW-1:0]     c_re_reg;
    logic signed [FW-1:0]     c_im_reg;
    logic signed [FW-1:0]     z_re_reg;
    logic signed [FW-1:0]     z_im_reg;
    logic [NW-1:0]            iter_reg;
    logic signed [PW-1:0]     pa_reg;
    logic signed [PW-1:0]     pb_reg;
    logic signed [PW-1:0]     pc_reg;
    logic [NW-1:0]            count_reg;
    logic                     escaped_reg;

    logic [CW:0]              col_in;
    logic [CW:0]              row_in;
    logic signed [OW-1:0]     off_re;
    logic signed [OW-1:0]     off_im;
    logic signed [FW-1:0]     mul_a0;
    logic signed [FW-1:0]     mul_a1;
    logic signed [FW-1:0]     mul_b0;
    logic signed [FW-1:0]     mul_b1;
    logic signed [PW-1:0]     pa_next;
    logic signed [PW-1:0]     pb_next;
    logic signed [PW-1:0]     pc_next;
    logic signed [WW-1:0]     map_re;
    logic signed [WW-1:0]     map_im;
    logic signed [WW-1:0]     new_re;
    logic signed [WW-1:0]     new_im;
    logic [PW:0]              mag;

    // clamp pixel to the frame
    assign col_in = ({1'b0, pixel_col} > COL_LAST) ? COL_LAST : {1'b0, pixel_col};
    assign row_in = ({1'b0, pixel_row} > ROW_LAST) ? ROW_LAST : {1'b0, pixel_row};

    assign off_re = $signed(OW'(col_reg)) + OW'(cfg.column_shift);
    assign off_im = $signed(OW'(row_reg)) + OW'(cfg.row_shift);

    // operand select: mapping uses offset*step, iteration uses z products
    always_comb
    begin
        if (cmd.map_mul)
        begin
            mul_a0 = FW'(off_re);
            mul_a1 = cfg.real_step;
            mul_b0 = FW'(off_im);
            mul_b1 = cfg.imag_step;
        end
        else
        begin
            mul_a0 = z_re_reg;
            mul_a1 = z_re_reg;
            mul_b0 = z_im_reg;
            mul_b1 = z_im_reg;
        end
    end

    assign pa_next = mul_a0 * mul_a1;
    assign pb_next = mul_b0 * mul_b1;
    assign pc_next = z_re_reg * z_im_reg;

    assign map_re = WW'(cfg.real_axis_min) + WW'(pa_reg);
    assign map_im = WW'(cfg.imag_axis_min) + WW'(pb_reg);

    // z*z + c; the imaginary part keeps one more fraction bit for the 2*re*im
    assign new_re = (WW'(pa_reg) - WW'(pb_reg) + (WW'(c_re_reg) <<< FB)) >>> FB;
    assign new_im = (WW'(pc_reg) + (WW'(c_im_reg) <<< (FB - 1))) >>> (FB - 1);

    // squares of the current z are in pa/pb after the multiply cycle
    assign mag = {1'b0, pa_reg} + {1'b0, pb_reg};

    assign stat.escape   = (iter_reg != '0) && (mag > mpec_pkg::ESCAPE_BOUND);
    assign stat.at_limit = (iter_reg == NW'(cfg.iteration_limit));

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            col_reg <= col_in;
            row_reg <= row_in;
        end
        if (cmd.map_mul || cmd.iter_mul)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
        end
        if (cmd.map_add)
        begin
            c_re_reg <= mpec_pkg::sat32(map_re);
            c_im_reg <= mpec_pkg::sat32(map_im);
            z_re_reg <= mpec_pkg::sat32(map_re);
            z_im_reg <= mpec_pkg::sat32(map_im);
        end
        else if (cmd.iter_upd)
        begin
            z_re_reg <= mpec_pkg::sat32(new_re);
            z_im_reg <= mpec_pkg::sat32(new_im);
        end
        if (cmd.finish)
        begin
            count_reg   <= stat.escape ? iter_reg : NW'(cfg.iteration_limit) + NW'(1);
            escaped_reg <= stat.escape;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (cmd.map_add)
        begin
            iter_reg <= '0;
        end
        else if (cmd.iter_upd)
        begin
            iter_reg <= iter_reg + NW'(1);
        end
    end

    assign iteration_count = count_reg;
    assign escaped         = escaped_reg;

endmodule

// ===== rtl/mandelbrot_pixel_escape_count.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_pixel_escape_count
// Escape-time counter for one pixel in signed Q8.24 fixed point.
// Each item is accepted, mapped (multiply, then add) and iterated until it
//   escapes or reaches the limit; a new item is taken only once the sequencer is idle.
// Each iteration uses one step on the three-multiplier unit and one step for
//   the z update/escape test.
// Reset: rst_n is asynchronous, active low; config registers return to their
//   reset values, the sequencer goes idle and no result is held.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape_count
#(
    parameter int FRAME_WIDTH  = mpec_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = mpec_pkg::FRAME_HEIGHT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mpec_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mpec_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mpec_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,

    // pixel items in, result items out
    mpec_pixel_if.sink                          pixel,
    mpec_result_if.source                       result
);

    mpec_pkg::cfg_t      cfg;
    mpec_pkg::ctrl_cmd_t cmd;
    mpec_pkg::dp_stat_t  stat;

    // no wait states on the register port
    assign pready = 1'b1;

    // register file: window origin, step, pixel shifts and iteration limit
    mpec_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // sequencer: IDLE -> map multiply -> map add -> (multiply, update)* ;
    // the result register decouples the output so a new pixel can be taken
    // while the previous result still waits
    mpec_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: point mapping and z = z*z + c with full-width products,
    // floor shift and saturation; |z|^2 > 4 tested on the next squares
    mpec_dp
    #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .pixel_col       (pixel.pixel_col),
        .pixel_row       (pixel.pixel_row),
        .iteration_count (result.iteration_count),
        .escaped         (result.escaped)
    );

endmodule
